@@ design/dabr_pkg.sv @@
// Shared widths, codes and beat types of the depth-aware bilinear remapper.
package dabr_pkg;

  localparam int unsigned COL_W   = 11;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned WT_W    = 11;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned MODE_W  = 2;
  // Linear address incl. the lower-right neighbour: 2047*4095 + 2047 + 4095 + 1 < 2**24
  localparam int unsigned BASE_W  = 24;
  localparam int unsigned PROD_W  = PIX_W + WT_W;
  localparam int unsigned ACC_W   = PROD_W + 3;
  localparam int unsigned SPR_W   = 2 * PIX_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_REMAP = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;

  localparam logic [MODE_W-1:0]  RST_MODE   = 2'd0;
  localparam logic [DIM_W-1:0]   RST_WIDTH  = 12'd1280;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 12'd720;
  localparam logic [RATIO_W-1:0] RST_RATIO  = 16'd3076;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_RATIO  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OUTC_OK       = 2'd0,
    OUTC_INVALID  = 2'd1,
    OUTC_ZERO_NBR = 2'd2,
    OUTC_DISCONT  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_NEAREST = 2'd1,
    KIND_BILIN   = 2'd2,
    KIND_DEPTH   = 2'd3
  } kind_t;

  typedef struct packed {
    logic                       operation;
    logic [COL_W-1:0]           col;
    logic [COL_W-1:0]           row;
    logic [PIX_W-1:0]           pixel_in;
    logic                       entry_valid;
    logic [3:0][WT_W-1:0]       weight;
  } item_t;

  // One neighbour read on its way from the sequencer to the interpolator.
  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic            first;
    logic            last;
    logic            oob;
    logic [WT_W-1:0] weight;
  } rd_tok_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
    outcome_t         outcome;
  } res_t;

endpackage

@@ design/dabr_if.sv @@
// Input and result channel interfaces of the remapper.
interface dabr_in_if import dabr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [COL_W-1:0]    col;
  logic [COL_W-1:0]    row;
  logic [PIX_W-1:0]    pixel_in;
  logic                entry_valid;
  logic [WT_W-1:0]     weight_ul;
  logic [WT_W-1:0]     weight_ur;
  logic [WT_W-1:0]     weight_ll;
  logic [WT_W-1:0]     weight_lr;

  modport source (
    output valid, operation, col, row, pixel_in, entry_valid,
    output weight_ul, weight_ur, weight_ll, weight_lr,
    input  ready
  );
  modport sink (
    input  valid, operation, col, row, pixel_in, entry_valid,
    input  weight_ul, weight_ur, weight_ll, weight_lr,
    output ready
  );
endinterface

interface dabr_out_if import dabr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [1:0]       outcome;

  modport source (output valid, pixel_out, outcome, input ready);
  modport sink   (input valid, pixel_out, outcome, output ready);
endinterface

@@ design/dabr_frame_ram.sv @@
// Single-port source frame memory with registered read.
module dabr_frame_ram import dabr_pkg::*; #(
  parameter int unsigned DEPTH = 1048576,
  parameter int unsigned ADDR_W = 20
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ design/dabr_addr_seq.sv @@
// Input register, base address multiply and neighbour read/write sequencer.
module dabr_addr_seq import dabr_pkg::*; #(
  parameter int unsigned FRAME_PIXELS = 1048576,
  parameter int unsigned ADDR_W = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  dabr_in_if.sink            item,
  input  logic [MODE_W-1:0]  interp_mode,
  input  logic [DIM_W-1:0]   img_width,
  input  logic [DIM_W-1:0]   img_height,
  output logic               mem_we,
  output logic               mem_re,
  output logic [ADDR_W-1:0]  mem_addr,
  output logic [PIX_W-1:0]   mem_wdata,
  output rd_tok_t            tok
);

  localparam logic [BASE_W-1:0] FrameLim = BASE_W'(FRAME_PIXELS);

  logic              a_valid;
  item_t             a_item;
  kind_t             a_kind;
  logic              a_move;

  logic              b_valid;
  logic              b_op;
  kind_t             b_kind;
  logic [BASE_W-1:0] b_base;
  logic [PIX_W-1:0]  b_pix;
  logic [3:0][WT_W-1:0] b_wt;
  logic [1:0]        b_step;
  logic              b_last;
  logic              b_free;

  logic [BASE_W-1:0] lim;
  logic [BASE_W-1:0] area;
  logic [DIM_W:0]    offset;
  logic [BASE_W-1:0] rd_addr;
  logic              in_rng;
  rd_tok_t           tok_next;

  // Valid addresses end at min(width * height, frame size)
  assign area = BASE_W'(img_width) * BASE_W'(img_height);

  always_ff @(posedge clk) begin
    lim <= (area < FrameLim) ? area : FrameLim;
  end

  always_comb begin
    if (!a_item.entry_valid) begin
      a_kind = KIND_INVALID;
    end else if (interp_mode == MODE_NEAREST) begin
      a_kind = KIND_NEAREST;
    end else if (interp_mode[1]) begin
      a_kind = KIND_DEPTH;
    end else begin
      a_kind = KIND_BILIN;
    end
  end

  assign b_last = (b_op == OP_LOAD) || (b_kind == KIND_INVALID) ||
                  (b_kind == KIND_NEAREST) || (b_step == 2'd3);
  assign b_free = !b_valid || b_last;
  assign a_move = adv && a_valid && b_free;
  assign item.ready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= (a_valid && !a_move) || item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      a_item.operation   <= item.operation;
      a_item.col         <= item.col;
      a_item.row         <= item.row;
      a_item.pixel_in    <= item.pixel_in;
      a_item.entry_valid <= item.entry_valid;
      a_item.weight      <= {item.weight_lr, item.weight_ll, item.weight_ur, item.weight_ul};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_step  <= 2'd0;
    end else if (a_move) begin
      b_valid <= 1'b1;
      b_step  <= 2'd0;
    end else if (adv && b_valid) begin
      if (b_last) begin
        b_valid <= 1'b0;
      end else begin
        b_step <= b_step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_op   <= a_item.operation;
      b_kind <= a_kind;
      b_base <= BASE_W'(a_item.row) * BASE_W'(img_width) + BASE_W'(a_item.col);
      b_pix  <= a_item.pixel_in;
      b_wt   <= a_item.weight;
    end
  end

  // Neighbours sit at base, base+1, base+width, base+width+1
  always_comb begin
    case (b_step)
      2'd0:    offset = '0;
      2'd1:    offset = (DIM_W+1)'(1);
      2'd2:    offset = (DIM_W+1)'(img_width);
      default: offset = (DIM_W+1)'(img_width) + (DIM_W+1)'(1);
    endcase
  end

  assign rd_addr   = b_base + BASE_W'(offset);
  assign in_rng    = rd_addr < lim;
  assign mem_addr  = rd_addr[ADDR_W-1:0];
  assign mem_wdata = b_pix;
  assign mem_we    = adv && b_valid && (b_op == OP_LOAD) && in_rng;
  assign mem_re    = adv && b_valid && (b_op == OP_REMAP) && (b_kind != KIND_INVALID) && in_rng;

  always_comb begin
    tok_next.valid  = b_valid && (b_op == OP_REMAP);
    tok_next.kind   = b_kind;
    tok_next.first  = (b_step == 2'd0);
    tok_next.last   = b_last;
    tok_next.oob    = !in_rng;
    tok_next.weight = b_wt[b_step];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (adv) begin
      tok <= tok_next;
    end
  end

endmodule

@@ design/dabr_interp.sv @@
// Multiply-accumulate over returned neighbours, depth checks and result select.
module dabr_interp import dabr_pkg::*; #(
  parameter int unsigned WEIGHT_FRAC_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  rd_tok_t            tok,
  input  logic [PIX_W-1:0]   rdata,
  input  logic [RATIO_W-1:0] discontinuity_ratio,
  output res_t               res
);

  localparam logic [ACC_W-1:0] RoundK = ACC_W'(1) << (WEIGHT_FRAC_BITS - 1);

  logic              p_valid;
  kind_t             p_kind;
  logic              p_first;
  logic              p_last;
  logic [PIX_W-1:0]  p_n;
  logic [PROD_W-1:0] p_prod;
  logic [PIX_W-1:0]  nbr;

  logic [ACC_W-1:0]  acc;
  logic [PIX_W-1:0]  mn;
  logic [PIX_W-1:0]  mx;
  logic [ACC_W-1:0]  acc_next;
  logic [PIX_W-1:0]  mn_next;
  logic [PIX_W-1:0]  mx_next;

  logic              f_valid;
  kind_t             f_kind;
  logic [ACC_W-1:0]  f_acc;
  logic [PIX_W-1:0]  f_mn;
  logic [PIX_W-1:0]  f_mx;

  logic [ACC_W-1:0]  rounded;
  logic [ACC_W-1:0]  shifted;
  logic [SPR_W-1:0]  spread;
  logic [SPR_W-1:0]  thresh;

  logic              g_valid;
  kind_t             g_kind;
  logic              g_zero;
  logic              g_disc;
  logic [PIX_W-1:0]  g_sum;
  logic [PIX_W-1:0]  g_near;

  // Out-of-frame neighbours read as zero
  assign nbr = tok.oob ? '0 : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= tok.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_kind  <= tok.kind;
      p_first <= tok.first;
      p_last  <= tok.last;
      p_n     <= nbr;
      p_prod  <= PROD_W'(nbr) * PROD_W'(tok.weight);
    end
  end

  always_comb begin
    acc_next = (p_first ? '0 : acc) + ACC_W'(p_prod);
    mn_next  = (p_first || p_n < mn) ? p_n : mn;
    mx_next  = (p_first || p_n > mx) ? p_n : mx;
  end

  always_ff @(posedge clk) begin
    if (adv && p_valid) begin
      acc <= acc_next;
      mn  <= mn_next;
      mx  <= mx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= p_valid && p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p_valid && p_last) begin
      f_kind <= p_kind;
      f_acc  <= acc_next;
      f_mn   <= mn_next;
      f_mx   <= mx_next;
    end
  end

  always_comb begin
    rounded = f_acc + RoundK;
    shifted = rounded >> WEIGHT_FRAC_BITS;
    spread  = {f_mx - f_mn, {PIX_W{1'b0}}};
    thresh  = SPR_W'(discontinuity_ratio) * SPR_W'(f_mn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && f_valid) begin
      g_kind <= f_kind;
      g_zero <= (f_mn == '0);
      g_disc <= spread > thresh;
      g_sum  <= (|shifted[ACC_W-1:PIX_W]) ? {PIX_W{1'b1}} : shifted[PIX_W-1:0];
      g_near <= f_mn;
    end
  end

  always_comb begin
    res.valid = g_valid;
    case (g_kind)
      KIND_INVALID: begin
        res.pixel   = '0;
        res.outcome = OUTC_INVALID;
      end
      KIND_NEAREST: begin
        res.pixel   = g_near;
        res.outcome = OUTC_OK;
      end
      KIND_BILIN: begin
        res.pixel   = g_sum;
        res.outcome = OUTC_OK;
      end
      default: begin
        if (g_zero) begin
          res.pixel   = '0;
          res.outcome = OUTC_ZERO_NBR;
        end else if (g_disc) begin
          res.pixel   = '0;
          res.outcome = OUTC_DISCONT;
        end else begin
          res.pixel   = g_sum;
          res.outcome = OUTC_OK;
        end
      end
    endcase
  end

endmodule

@@ design/depth_aware_bilinear_remap.sv @@
// Top level: register port, pipeline advance, result register and checks.
//
//   channel  dir  handshake            beat
//   item     in   valid/ready          load pixel or one lookup entry
//   result   out  valid/ready          pixel_out, outcome per remap entry
//   apb      in   psel/penable/pready  mode, width, height, ratio
//
// A bilinear or depth remap steps through the four neighbour reads on the single
// frame memory port; nearest, invalid and load beats take a single step.
// Reset clears control and loads register defaults; the frame memory is not cleared.
// A stalled result freezes the pipeline; the input register still takes one beat.
module depth_aware_bilinear_remap import dabr_pkg::*; #(
  parameter int unsigned FRAME_PIXELS = 1048576,
  parameter int unsigned WEIGHT_FRAC_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dabr_in_if.sink     item,
  dabr_out_if.source  result
);

  localparam int unsigned AddrW = $clog2(FRAME_PIXELS);

  logic [MODE_W-1:0]  interp_mode;
  logic [DIM_W-1:0]   img_width;
  logic [DIM_W-1:0]   img_height;
  logic [RATIO_W-1:0] discontinuity_ratio;

  logic              adv;
  logic              mem_we;
  logic              mem_re;
  logic [AddrW-1:0]  mem_addr;
  logic [PIX_W-1:0]  mem_wdata;
  logic [PIX_W-1:0]  mem_rdata;
  rd_tok_t           tok;
  res_t              res;

  logic              o_valid;
  logic [PIX_W-1:0]  o_pixel;
  outcome_t          o_outcome;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode         <= RST_MODE;
      img_width           <= RST_WIDTH;
      img_height          <= RST_HEIGHT;
      discontinuity_ratio <= RST_RATIO;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_MODE:   interp_mode         <= pwdata[MODE_W-1:0];
        REG_WIDTH:  img_width           <= pwdata[DIM_W-1:0];
        REG_HEIGHT: img_height          <= pwdata[DIM_W-1:0];
        REG_RATIO:  discontinuity_ratio <= pwdata[RATIO_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_MODE:   prdata = 32'(interp_mode);
      REG_WIDTH:  prdata = 32'(img_width);
      REG_HEIGHT: prdata = 32'(img_height);
      REG_RATIO:  prdata = 32'(discontinuity_ratio);
    endcase
  end

  // Whole pipeline moves unless a result is held
  assign adv = !o_valid || result.ready;

  dabr_addr_seq #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .ADDR_W       (AddrW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .item        (item),
    .interp_mode (interp_mode),
    .img_width   (img_width),
    .img_height  (img_height),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .tok         (tok)
  );

  dabr_frame_ram #(
    .DEPTH  (FRAME_PIXELS),
    .ADDR_W (AddrW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  dabr_interp #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_interp (
    .clk                 (clk),
    .rst                 (rst),
    .adv                 (adv),
    .tok                 (tok),
    .rdata               (mem_rdata),
    .discontinuity_ratio (discontinuity_ratio),
    .res                 (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      o_pixel   <= res.pixel;
      o_outcome <= res.outcome;
    end
  end

  assign result.valid     = o_valid;
  assign result.pixel_out = o_pixel;
  assign result.outcome   = o_outcome;

  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("frame memory written and read in one cycle");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !result.ready) |-> (!mem_we && !mem_re))
    else $error("frame memory accessed while result held");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_outcome != OUTC_OK) |-> (o_pixel == '0))
    else $error("rejected pixel not zero");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !result.ready) |=> (o_valid && $stable(o_pixel) && $stable(o_outcome)))
    else $error("held result changed");

endmodule

@@ test/testbench.sv @@
// Testbench of depth_aware_bilinear_remap: directed plan, then random phases vs predictor.
`timescale 1ns / 100ps

module testbench;
  import dabr_pkg::*;

  localparam int unsigned FRAME_PIXELS     = 1048576;
  localparam int unsigned WEIGHT_FRAC_BITS = 10;
  localparam int          CYCLE_LIMIT      = 600000;
  localparam int          DRAIN_CYCLES     = 24;
  localparam int          N_PHASES         = 14;
  localparam int          PHASE_ITEMS      = 90;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    outcome_t         outcome;
  } remap_res_t;

  typedef enum bit {ROW_REG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    reg_idx_t         idx;
    int unsigned      value;
    item_t            beat;
    bit               typed;
    logic [PIX_W-1:0] px;
    outcome_t         oc;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dabr_in_if  in_ch ();
  dabr_out_if out_ch ();

  depth_aware_bilinear_remap u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (in_ch),
    .result  (out_ch)
  );

  // Predictor state: register copies and the frame contents written so far.
  logic [MODE_W-1:0]  cur_mode;
  logic [DIM_W-1:0]   cur_width;
  logic [DIM_W-1:0]   cur_height;
  logic [RATIO_W-1:0] cur_ratio;
  logic [PIX_W-1:0]   frame_mem [int unsigned];
  int unsigned        written_q [$];

  remap_res_t remap_q [$];
  plan_row_t  plan [$];
  int         mismatches;
  int         cycles;
  bit         calm;
  int unsigned depth_lvl;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic longint unsigned frame_span();
    longint unsigned lim;
    lim = 64'(cur_width) * 64'(cur_height);
    if (lim > FRAME_PIXELS) lim = FRAME_PIXELS;
    return lim;
  endfunction

  function automatic logic [PIX_W-1:0] pixel_at(longint unsigned addr);
    if (addr >= frame_span()) return '0;
    return frame_mem.exists(int'(addr)) ? frame_mem[int'(addr)] : '0;
  endfunction

  function automatic remap_res_t predict_remap(item_t it);
    remap_res_t      res;
    longint unsigned base, w, acc, lo, hi;
    longint unsigned nb [4];
    res.pixel   = '0;
    res.outcome = OUTC_OK;
    w    = 64'(cur_width);
    base = 64'(it.row) * w + 64'(it.col);
    if (!it.entry_valid) begin
      res.outcome = OUTC_INVALID;
    end else if (cur_mode == MODE_NEAREST) begin
      res.pixel = pixel_at(base);
    end else begin
      nb[0] = pixel_at(base);
      nb[1] = pixel_at(base + 1);
      nb[2] = pixel_at(base + w);
      nb[3] = pixel_at(base + w + 1);
      lo = nb[0];
      hi = nb[0];
      for (int k = 1; k < 4; k++) begin
        if (nb[k] < lo) lo = nb[k];
        if (nb[k] > hi) hi = nb[k];
      end
      if (cur_mode[1] && lo == 0) begin
        res.outcome = OUTC_ZERO_NBR;
      end else if (cur_mode[1] && ((hi - lo) << 16) > 64'(cur_ratio) * lo) begin
        res.outcome = OUTC_DISCONT;
      end else begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += nb[k] * 64'(it.weight[k]);
        acc = (acc + (64'd1 << (WEIGHT_FRAC_BITS - 1))) >> WEIGHT_FRAC_BITS;
        res.pixel = (acc > 65535) ? 16'hFFFF : acc[15:0];
      end
    end
    return res;
  endfunction

  // True when every frame word this remap reads is either written or outside the frame.
  function automatic bit reads_known(int unsigned c, int unsigned r);
    longint unsigned base, w, lim;
    longint unsigned addr [4];
    int              cnt;
    w    = 64'(cur_width);
    lim  = frame_span();
    base = 64'(r) * w + 64'(c);
    addr[0] = base;
    addr[1] = base + 1;
    addr[2] = base + w;
    addr[3] = base + w + 1;
    cnt = (cur_mode == MODE_NEAREST) ? 1 : 4;
    for (int k = 0; k < cnt; k++)
      if (addr[k] < lim && !frame_mem.exists(int'(addr[k]))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic item_t mk_item(logic op, int unsigned c, int unsigned r,
                                    int unsigned pix, logic v, int unsigned w0,
                                    int unsigned w1, int unsigned w2, int unsigned w3);
    item_t it;
    it.operation   = op;
    it.col         = COL_W'(c);
    it.row         = COL_W'(r);
    it.pixel_in    = PIX_W'(pix);
    it.entry_valid = v;
    it.weight[0]   = WT_W'(w0);
    it.weight[1]   = WT_W'(w1);
    it.weight[2]   = WT_W'(w2);
    it.weight[3]   = WT_W'(w3);
    return it;
  endfunction

  function automatic void plan_reg(reg_idx_t idx, int unsigned value);
    plan_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.value = value;
    row.beat  = '0;
    row.typed = 1'b0;
    row.px    = '0;
    row.oc    = OUTC_OK;
    plan.push_back(row);
  endfunction

  function automatic void plan_beat(item_t it, bit typed, int unsigned px, outcome_t oc);
    plan_row_t row;
    row.kind  = ROW_BEAT;
    row.idx   = REG_MODE;
    row.value = 0;
    row.beat  = it;
    row.typed = typed;
    row.px    = PIX_W'(px);
    row.oc    = oc;
    plan.push_back(row);
  endfunction

  // Mostly a smooth depth surface, with zeros and arbitrary values mixed in.
  function automatic int unsigned pix_val();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 0;
    if (pick < 20) return $urandom_range(0, 65535);
    return depth_lvl + $urandom_range(0, depth_lvl / 32 + 1);
  endfunction

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODE:   cur_mode   = MODE_W'(val);
      REG_WIDTH:  cur_width  = DIM_W'(val);
      REG_HEIGHT: cur_height = DIM_W'(val);
      REG_RATIO:  cur_ratio  = RATIO_W'(val);
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_item(item_t it, bit typed, logic [PIX_W-1:0] tpx, outcome_t toc);
    int              gap;
    remap_res_t      want;
    longint unsigned base;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.operation   = it.operation;
    in_ch.col         = it.col;
    in_ch.row         = it.row;
    in_ch.pixel_in    = it.pixel_in;
    in_ch.entry_valid = it.entry_valid;
    in_ch.weight_ul   = it.weight[0];
    in_ch.weight_ur   = it.weight[1];
    in_ch.weight_ll   = it.weight[2];
    in_ch.weight_lr   = it.weight[3];
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (it.operation == OP_LOAD) begin
      base = 64'(it.row) * 64'(cur_width) + 64'(it.col);
      if (base < frame_span()) begin
        if (!frame_mem.exists(int'(base))) written_q.push_back(int'(base));
        frame_mem[int'(base)] = it.pixel_in;
      end
    end else begin
      want = predict_remap(it);
      if (typed) begin
        want.pixel   = tpx;
        want.outcome = toc;
      end
      remap_q.push_back(want);
    end
  endtask

  // Drop valid, wait out every pending result and let trailing loads settle.
  task automatic drain_pipe();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (remap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_at(int unsigned addr);
    int unsigned w;
    w = cur_width;
    if (w == 0 || 64'(addr) >= frame_span() || addr % w > 2047 || addr / w > 2047) return;
    send_item(mk_item(OP_LOAD, addr % w, addr / w, pix_val(), $urandom_range(0, 1),
                      $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 2047)),
              1'b0, '0, OUTC_OK);
  endtask

  task automatic send_remap(int unsigned c, int unsigned r, bit v);
    int unsigned w0, w1, w2, w3;
    if ($urandom_range(0, 3) == 0) begin
      w0 = $urandom_range(0, 2047);
      w1 = $urandom_range(0, 2047);
      w2 = $urandom_range(0, 2047);
      w3 = $urandom_range(0, 2047);
    end else begin
      w0 = $urandom_range(0, 1024);
      w1 = $urandom_range(0, 1024 - w0);
      w2 = $urandom_range(0, 1024 - w0 - w1);
      w3 = 1024 - w0 - w1 - w2;
    end
    // Never let a valid remap touch a frame word that was never written.
    if (v && !reads_known(c, r)) v = 1'b0;
    send_item(mk_item(OP_REMAP, c, r, $urandom_range(0, 65535), v, w0, w1, w2, w3),
              1'b0, '0, OUTC_OK);
  endtask

  task automatic random_step(output int n);
    int unsigned     pick, a, c, r, w, col_hi, row_hi;
    longint unsigned lim;
    n    = 1;
    pick = $urandom_range(0, 99);
    lim  = frame_span();
    w    = cur_width;
    if (pick < 35 && lim > 0) begin
      // Neighbourhood: load the 2x2 block, then remap it.
      row_hi = int'((lim - 1) / w);
      if (row_hi > 2047) row_hi = 2047;
      col_hi = (w > 2048) ? 2047 : w - 1;
      r = ($urandom_range(0, 9) == 0) ? row_hi : $urandom_range(0, row_hi);
      c = $urandom_range(0, col_hi);
      a = r * w + c;
      load_at(a);
      load_at(a + 1);
      load_at(a + w);
      load_at(a + w + 1);
      send_remap(c, r, $urandom_range(0, 19) != 0);
      n = 5;
    end else if (pick < 75) begin
      if (written_q.size() > 0 && $urandom_range(0, 9) < 7) begin
        a = written_q[$urandom_range(0, written_q.size() - 1)];
        case ($urandom_range(0, 2))
          1: if (a > 0) a = a - 1;
          2: if (a >= w) a = a - w;
          default: ;
        endcase
        c = a % w;
        r = a / w;
        if (c > 2047 || r > 2047) begin
          c = $urandom_range(0, 2047);
          r = $urandom_range(0, 2047);
        end
      end else begin
        c = $urandom_range(0, 2047);
        r = $urandom_range(0, 2047);
      end
      // Same linear address reached through a column past the row end.
      if (r > 0 && c + w <= 2047 && $urandom_range(0, 4) == 0) begin
        c = c + w;
        r = r - 1;
      end
      send_remap(c, r, $urandom_range(0, 9) != 0);
    end else if (pick < 90) begin
      if (lim > 0 && $urandom_range(0, 1) == 1) begin
        load_at($urandom_range(0, int'(lim - 1)));
      end else begin
        send_item(mk_item(OP_LOAD, $urandom_range(0, 2047), $urandom_range(0, 2047),
                          pix_val(), $urandom_range(0, 1), $urandom_range(0, 2047),
                          $urandom_range(0, 2047), $urandom_range(0, 2047),
                          $urandom_range(0, 2047)),
                  1'b0, '0, OUTC_OK);
      end
    end else begin
      send_item(mk_item(OP_REMAP, $urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 65535), 1'b0, $urandom_range(0, 2047),
                        $urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 2047)),
                1'b0, '0, OUTC_OK);
    end
  endtask

  always @(posedge clk) begin : check_results
    remap_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (remap_q.size() == 0) begin
        $error("result beat with nothing pending: pixel_out %0d outcome %0d",
               out_ch.pixel_out, out_ch.outcome);
        mismatches++;
      end else begin
        want = remap_q.pop_front();
        if (out_ch.pixel_out !== want.pixel) begin
          $error("pixel_out: expected %0d, actual %0d", want.pixel, out_ch.pixel_out);
          mismatches++;
        end
        if (out_ch.outcome !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, out_ch.outcome);
          mismatches++;
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    int          n, sent;
    int unsigned m, w, h, rt;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_LOAD;
    in_ch.col         = '0;
    in_ch.row         = '0;
    in_ch.pixel_in    = '0;
    in_ch.entry_valid = 1'b0;
    in_ch.weight_ul   = '0;
    in_ch.weight_ur   = '0;
    in_ch.weight_ll   = '0;
    in_ch.weight_lr   = '0;
    mismatches        = 0;
    cycles            = 0;
    calm              = 1'b0;
    depth_lvl         = 1000;
    cur_mode          = RST_MODE;
    cur_width         = RST_WIDTH;
    cur_height        = RST_HEIGHT;
    cur_ratio         = RST_RATIO;

    // Directed plan, starting from the reset register values (1280 x 720, nearest).
    plan_beat(mk_item(OP_LOAD, 0, 0, 'h1234, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_REMAP, 0, 0, 0, 1, 0, 0, 0, 0), 1, 'h1234, OUTC_OK);
    plan_beat(mk_item(OP_REMAP, 2047, 2047, 'hFFFF, 0, 2047, 2047, 2047, 2047),
              1, 0, OUTC_INVALID);
    plan_beat(mk_item(OP_LOAD, 2047, 2047, 'hBEEF, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_REMAP, 2047, 2047, 0, 1, 1024, 0, 0, 0), 1, 0, OUTC_OK);
    plan_beat(mk_item(OP_LOAD, 1279, 719, 'hFFFF, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_REMAP, 1279, 719, 0, 1, 0, 0, 0, 0), 1, 'hFFFF, OUTC_OK);
    plan_reg(REG_MODE, 1);
    plan_beat(mk_item(OP_LOAD, 1, 0, 'h1000, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_LOAD, 0, 1, 'h2000, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_LOAD, 1, 1, 'h3000, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_REMAP, 0, 0, 0, 1, 1024, 0, 0, 0), 1, 'h1234, OUTC_OK);
    plan_beat(mk_item(OP_REMAP, 0, 0, 0, 1, 256, 256, 256, 256), 0, 0, OUTC_OK);
    // Last frame pixel with all-max weights: the sum saturates.
    plan_beat(mk_item(OP_REMAP, 1279, 719, 0, 1, 2047, 2047, 2047, 2047),
              1, 'hFFFF, OUTC_OK);
    plan_reg(REG_MODE, 2);
    plan_beat(mk_item(OP_REMAP, 1279, 719, 0, 1, 256, 256, 256, 256),
              1, 0, OUTC_ZERO_NBR);
    plan_beat(mk_item(OP_REMAP, 0, 0, 0, 1, 256, 256, 256, 256), 1, 0, OUTC_DISCONT);
    plan_beat(mk_item(OP_LOAD, 4, 0, 1000, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_LOAD, 5, 0, 1040, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_LOAD, 4, 1, 1020, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_LOAD, 5, 1, 1000, 1, 0, 0, 0, 0), 0, 0, OUTC_OK);
    plan_beat(mk_item(OP_REMAP, 4, 0, 0, 1, 1024, 0, 0, 0), 1, 1000, OUTC_OK);
    plan_reg(REG_RATIO, 0);
    plan_beat(mk_item(OP_REMAP, 4, 0, 0, 1, 256, 256, 256, 256), 1, 0, OUTC_DISCONT);
    plan_reg(REG_MODE, 3);
    plan_reg(REG_RATIO, 65535);
    plan_beat(mk_item(OP_REMAP, 4, 0, 0, 1, 300, 200, 400, 124), 0, 0, OUTC_OK);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain_pipe();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_item(plan[i].beat, plan[i].typed, plan[i].px, plan[i].oc);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       begin m = 1; w = 8;    h = 6;    rt = 3076;  end
        1:       begin m = 2; w = 5;    h = 4;    rt = 3076;  end
        2:       begin m = 0; w = 1;    h = 1;    rt = 3076;  end
        3:       begin m = 2; w = 16;   h = 3;    rt = 0;     end
        4:       begin m = 3; w = 7;    h = 7;    rt = 65535; end
        5:       begin m = 1; w = 2048; h = 2048; rt = 3076;  end
        6:       begin m = 2; w = 2048; h = 1;    rt = 20000; end
        7:       begin m = 0; w = 1;    h = 2048; rt = 100;   end
        8:       begin m = 2; w = 12;   h = 0;    rt = 3076;  end
        9:       begin m = 3; w = 4095; h = 300;  rt = 6000;  end
        default: begin
          m  = $urandom_range(0, 3);
          w  = $urandom_range(1, 24);
          h  = $urandom_range(1, 24);
          rt = $urandom_range(0, 65535);
        end
      endcase
      drain_pipe();
      write_reg(REG_MODE, m);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_RATIO, rt);
      calm      = ($urandom_range(0, 3) == 0);
      depth_lvl = $urandom_range(64, 60000);
      if (frame_span() <= 400)
        for (int unsigned a = 0; a < frame_span(); a++) load_at(a);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_step(n);
        sent += n;
      end
    end

    drain_pipe();
    if (mismatches == 0 && remap_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/dabr_pkg.sv
design/dabr_if.sv
design/dabr_frame_ram.sv
design/dabr_addr_seq.sv
design/dabr_interp.sv
design/depth_aware_bilinear_remap.sv
test/testbench.sv
